// ===== sv/sirf_pkg.sv =====
package sirf_pkg;

    // Image side and the index widths that follow from it
    localparam int SIDE   = 32;
    localparam int IDX_W  = (SIDE > 1) ? $clog2(SIDE) : 1;
    localparam int DEPTH  = SIDE * SIDE;
    localparam int ADDR_W = $clog2(DEPTH);

    // Fixed field widths of the channels
    localparam int CMD_W   = 2;
    localparam int COORD_W = 5;
    localparam int PIX_W   = 8;
    localparam int OP_W    = 2;
    localparam int CNT_W   = 8;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_XFORM = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    // Transform codes
    localparam logic [OP_W-1:0] OP_ROT_CW  = 2'd0;
    localparam logic [OP_W-1:0] OP_ROT_CCW = 2'd1;
    localparam logic [OP_W-1:0] OP_FLIP_TB = 2'd2;
    localparam logic [OP_W-1:0] OP_FLIP_LR = 2'd3;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic             wr_en;
        logic             xform_en;
        logic             row_load;
        logic             rd_en;
        logic [IDX_W-1:0] rd_col;
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic row_ok;
        logic col_ok;
        logic out_free;
    } t_dp_stat;

    // Map a position of the current image to a memory address
    function automatic logic [ADDR_W-1:0] phys_addr(
        input logic [IDX_W-1:0] r,
        input logic [IDX_W-1:0] c,
        input logic [1:0]       turns,
        input logic             mirror
    );
        logic [IDX_W-1:0] max_idx;
        logic [IDX_W-1:0] pr;
        logic [IDX_W-1:0] pc;
        max_idx = IDX_W'(SIDE - 1);
        unique case (turns)
            2'd0: begin
                pr = r;
                pc = c;
            end
            2'd1: begin
                pr = max_idx - c;
                pc = r;
            end
            2'd2: begin
                pr = max_idx - r;
                pc = max_idx - c;
            end
            default: begin
                pr = c;
                pc = max_idx - r;
            end
        endcase
        if (mirror) begin
            pc = max_idx - pc;
        end
        return ADDR_W'(ADDR_W'(pr) * ADDR_W'(SIDE) + ADDR_W'(pc));
    endfunction

endpackage

// ===== sv/sirf_in_if.sv =====
interface sirf_in_if import sirf_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   cmd;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [PIX_W-1:0]   pixel;
    logic [OP_W-1:0]    op;
    logic [CNT_W-1:0]   count;

    modport source (output valid, cmd, row, col, pixel, op, count, input ready);
    modport sink   (input valid, cmd, row, col, pixel, op, count, output ready);
endinterface

// ===== sv/sirf_out_if.sv =====
interface sirf_out_if import sirf_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [PIX_W-1:0]   out_pixel;
    logic [COORD_W-1:0] out_col;
    logic               last;

    modport source (output valid, out_pixel, out_col, last, input ready);
    modport sink   (input valid, out_pixel, out_col, last, output ready);
endinterface

// ===== sv/sirf_ram.sv =====
module sirf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // hold read data while no read is issued
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== sv/sirf_ctrl.sv =====
module sirf_ctrl import sirf_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [CMD_W-1:0] i_cmd,
    input  t_dp_stat         i_stat,
    output logic             o_in_ready,
    output t_dp_cmd          o_cmd
);
    typedef enum logic {
        ST_IDLE,
        ST_READ
    } t_state;

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_col, n_col;
    logic             r_in_ready, n_in_ready;
    logic             accept;
    logic             issue;

    assign accept = i_in_valid && r_in_ready;
    assign issue  = (r_state == ST_READ) && i_stat.out_free;

    always_comb begin
        n_state    = r_state;
        n_col      = r_col;
        n_in_ready = r_in_ready;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && i_cmd == CMD_READ && i_stat.row_ok) begin
                    n_state    = ST_READ;
                    n_col      = '0;
                    n_in_ready = 1'b0;
                end
            end
            ST_READ: begin
                if (issue) begin
                    // advance through the row, drop back to idle after the last column
                    n_col = r_col + 1'b1;
                    if (r_col == IDX_W'(SIDE - 1)) begin
                        n_state    = ST_IDLE;
                        n_in_ready = 1'b1;
                    end
                end
            end
            default: begin
                n_state    = ST_IDLE;
                n_in_ready = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_col      <= '0;
            r_in_ready <= 1'b1;
        end else begin
            r_state    <= n_state;
            r_col      <= n_col;
            r_in_ready <= n_in_ready;
        end
    end

    assign o_in_ready     = r_in_ready;
    assign o_cmd.wr_en    = accept && i_cmd == CMD_WRITE && i_stat.row_ok && i_stat.col_ok;
    assign o_cmd.xform_en = accept && i_cmd == CMD_XFORM;
    assign o_cmd.row_load = accept && i_cmd == CMD_READ;
    assign o_cmd.rd_en    = issue;
    assign o_cmd.rd_col   = r_col;
endmodule

// ===== sv/sirf_dp.sv =====
module sirf_dp import sirf_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    input  logic [COORD_W-1:0] i_row,
    input  logic [COORD_W-1:0] i_col,
    input  logic [PIX_W-1:0]   i_pixel,
    input  logic [OP_W-1:0]    i_op,
    input  logic [CNT_W-1:0]   i_count,
    input  logic               i_out_ready,
    output t_dp_stat           o_stat,
    output logic               o_out_valid,
    output logic [PIX_W-1:0]   o_out_pixel,
    output logic [COORD_W-1:0] o_out_col,
    output logic               o_out_last
);
    logic [1:0]         r_turns, n_turns;
    logic               r_mirror, n_mirror;
    logic [IDX_W-1:0]   r_row;
    logic               r_out_valid;
    logic [COORD_W-1:0] r_out_col;
    logic               r_out_last;
    logic [ADDR_W-1:0]  wr_addr;
    logic [ADDR_W-1:0]  rd_addr;

    assign o_stat.row_ok   = ({1'b0, i_row} < (COORD_W + 1)'(SIDE));
    assign o_stat.col_ok   = ({1'b0, i_col} < (COORD_W + 1)'(SIDE));
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    // Orientation: CW adds, CCW subtracts turns; odd flips fold turns, toggle mirror
    always_comb begin
        n_turns  = r_turns;
        n_mirror = r_mirror;
        if (i_cmd.xform_en) begin
            unique case (i_op)
                OP_ROT_CW:  n_turns = r_turns + i_count[1:0];
                OP_ROT_CCW: n_turns = r_turns - i_count[1:0];
                OP_FLIP_TB: begin
                    if (i_count[0]) begin
                        n_turns  = 2'd2 - r_turns;
                        n_mirror = !r_mirror;
                    end
                end
                OP_FLIP_LR: begin
                    if (i_count[0]) begin
                        n_turns  = 2'd0 - r_turns;
                        n_mirror = !r_mirror;
                    end
                end
                default: ;
            endcase
        end
    end

    assign wr_addr = phys_addr(IDX_W'(i_row), IDX_W'(i_col), r_turns, r_mirror);
    assign rd_addr = phys_addr(r_row, i_cmd.rd_col, r_turns, r_mirror);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_turns     <= '0;
            r_mirror    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_turns  <= n_turns;
            r_mirror <= n_mirror;
            if (i_cmd.rd_en) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.row_load) begin
            r_row <= IDX_W'(i_row);
        end
        if (i_cmd.rd_en) begin
            r_out_col  <= COORD_W'(i_cmd.rd_col);
            r_out_last <= (i_cmd.rd_col == IDX_W'(SIDE - 1));
        end
    end

    // The RAM read register doubles as the output pixel register
    sirf_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_en),
        .i_waddr (wr_addr),
        .i_wdata (i_pixel),
        .i_re    (i_cmd.rd_en),
        .i_raddr (rd_addr),
        .o_rdata (o_out_pixel)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_col   = r_out_col;
    assign o_out_last  = r_out_last;
endmodule

// ===== sv/square_image_rotate_flip_top.sv =====
// Channel  Dir  Payload                               Transfer
// i_in     in   cmd, row, col, pixel, op, count       valid && ready
// o_out    out  out_pixel, out_col, last              valid && ready
//
// A transform only updates the stored orientation; the pixel memory is never
// moved. A row read issues one column per cycle while o_out does not stall, set
// by the single read port of the pixel RAM, whose read register holds the
// output pixel.
// i_in.ready is low from a valid-row read until the last column is issued.
// A stall on o_out holds the current pixel and pauses the column counter.
// Synchronous active-low reset clears orientation and control; the pixel
// memory is not cleared.
module square_image_rotate_flip_top import sirf_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    sirf_in_if.sink    i_in,
    sirf_out_if.source o_out
);
    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // Sequence the commands: writes, transforms, column-by-column row reads
    sirf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_cmd      (i_in.cmd),
        .i_stat     (dp_stat),
        .o_in_ready (i_in.ready),
        .o_cmd      (dp_cmd)
    );

    // Hold orientation, map addresses and drive the output register
    sirf_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .i_row       (i_in.row),
        .i_col       (i_in.col),
        .i_pixel     (i_in.pixel),
        .i_op        (i_in.op),
        .i_count     (i_in.count),
        .i_out_ready (o_out.ready),
        .o_stat      (dp_stat),
        .o_out_valid (o_out.valid),
        .o_out_pixel (o_out.out_pixel),
        .o_out_col   (o_out.out_col),
        .o_out_last  (o_out.last)
    );
endmodule

// ===== sv/sirf_chk.sv =====
module sirf_chk import sirf_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic [PIX_W-1:0]   i_out_pixel,
    input logic [COORD_W-1:0] i_out_col,
    input logic               i_out_last
);
    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_pixel) && $stable(i_out_col) && $stable(i_out_last))
        else $error("stalled output changed");

    // No new item is taken while a row is still being emitted
    a_no_accept_mid_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_last |-> !i_in_ready)
        else $error("input ready in the middle of a row");

    // Columns follow each other without gaps
    a_col_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_out_last |=>
            i_out_valid && i_out_col == $past(i_out_col) + 1'b1)
        else $error("column sequence broken");

    // The last mark sits on the final column only
    a_last_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_last == (i_out_col == COORD_W'(SIDE - 1))))
        else $error("last mark on wrong column");
endmodule

bind square_image_rotate_flip_top sirf_chk u_sirf_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_pixel (o_out.out_pixel),
    .i_out_col   (o_out.out_col),
    .i_out_last  (o_out.last)
);
